// ===== design/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg: shared definitions for the range-max segment tree
// Action codes, the classified command that travels from the front end to the
// back end, queue sizing and the signed maximum helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

   // Default number of leaves.
   localparam int LEAVES_DEFAULT = 1024;

   // Field widths fixed by the transaction format.
   localparam int ACT_W   = 2;
   localparam int LEAF_W  = 10;
   localparam int VALUE_W = 64;
   localparam int RANGE_W = 11;

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CHMAX   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

   // Command queue between front and back end.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   // One classified command.
   typedef struct packed {
      logic [ACT_W-1:0]          action;
      logic                      leaf_ok;   // leaf index lies inside the tree
      logic [LEAF_W-1:0]         leaf_index;
      logic signed [VALUE_W-1:0] value;
      logic [RANGE_W-1:0]        range_lo;  // clamped to the leaf count
      logic [RANGE_W-1:0]        range_hi;  // clamped to the leaf count
      logic                      is_empty;  // query range holds no leaf
   } cmd_type;

   // Signed maximum of two node values.
   function automatic logic signed [VALUE_W-1:0] max_s64(
      input logic signed [VALUE_W-1:0] a,
      input logic signed [VALUE_W-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== design/rmst_ram.sv =====
// ----------------------------------------------------------------------------
// rmst_ram: generic RAM with one write port and two registered read ports
// Read data appears in the cycle after the address. A read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]         rd_a_data,
   output logic      [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

`default_nettype wire

// ===== design/rmst_queue.sv =====
// ----------------------------------------------------------------------------
// rmst_queue: command queue between the front and the back end
// A small FIFO of classified commands; the head is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_queue import rmst_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         full,
   output logic         empty
);

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff,  count_in;

   assign full  = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/rmst_front.sv =====
// ----------------------------------------------------------------------------
// rmst_front: request intake and classification
// Accepts request transactions, checks the leaf index, clamps the query range
// to the leaf count, flags empty ranges and pushes the command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_front import rmst_pkg::*; #(
   parameter int LEAVES = LEAVES_DEFAULT
) (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ACT_W-1:0]          req_action,
   input  wire logic [LEAF_W-1:0]         req_leaf_index,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [RANGE_W-1:0]        req_range_lo,
   input  wire logic [RANGE_W-1:0]        req_range_hi,
   input  wire logic                      queue_full,
   input  wire logic                      clear_busy,
   output logic                           push,
   output cmd_type                        push_cmd
);

   logic [RANGE_W-1:0] lo_clamp;
   logic [RANGE_W-1:0] hi_clamp;

   // Hold off requests while the queue is full or the store is being cleared.
   assign req_ready = !queue_full && !clear_busy;
   assign push      = req_valid && req_ready;

   // Range ends beyond the last leaf fall back to the leaf count.
   assign lo_clamp = (32'(req_range_lo) > LEAVES) ? RANGE_W'(LEAVES) : req_range_lo;
   assign hi_clamp = (32'(req_range_hi) > LEAVES) ? RANGE_W'(LEAVES) : req_range_hi;

   // Classified command.
   always_comb begin
      push_cmd.action     = req_action;
      push_cmd.leaf_ok    = (32'(req_leaf_index) < LEAVES);
      push_cmd.leaf_index = req_leaf_index;
      push_cmd.value      = req_value;
      push_cmd.range_lo   = lo_clamp;
      push_cmd.range_hi   = hi_clamp;
      push_cmd.is_empty   = (lo_clamp >= hi_clamp);
   end

endmodule

`default_nettype wire

// ===== design/rmst_back.sv =====
// ----------------------------------------------------------------------------
// rmst_back: tree sequencer
// Owns the node memory. Clears it after reset, then pops commands and walks
// the tree: leaf writes, bottom-up rebuild, leaf-to-root raise and bottom-up
// range query. Each result goes to an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_back import rmst_pkg::*; #(
   parameter int LEAVES = LEAVES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             head,
   input  wire logic                queue_empty,
   output logic                     pop,
   output logic                     clear_busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_max_value,
   output logic                     rsp_is_answer
);

   localparam int SPAN  = 1 << $clog2(LEAVES);
   localparam int NW    = $clog2(SPAN) + 1;   // node address bits
   localparam int DEPTH = 2 * SPAN;
   localparam int CW    = NW + 1;             // cursor bits, can hold DEPTH

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_RB_READ  = 4'd2;
   localparam logic [3:0] ST_RB_WRITE = 4'd3;
   localparam logic [3:0] ST_UP_READ  = 4'd4;
   localparam logic [3:0] ST_UP_WRITE = 4'd5;
   localparam logic [3:0] ST_Q_ISSUE  = 4'd6;
   localparam logic [3:0] ST_Q_FOLD   = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0]                state_ff,     state_in;
   logic [CW-1:0]             node_ff,      node_in;
   logic [CW-1:0]             rnode_ff,     rnode_in;
   logic signed [VALUE_W-1:0] value_ff,     value_in;
   logic signed [VALUE_W-1:0] best_ff,      best_in;
   logic                      use_l_ff,     use_l_in;
   logic                      use_r_ff,     use_r_in;
   logic                      is_answer_ff, is_answer_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_max_ff,   rsp_max_in;
   logic                      rsp_ans_ff,   rsp_ans_in;

   logic                      wr_en;
   logic [NW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [NW-1:0]             rd_a_addr;
   logic [NW-1:0]             rd_b_addr;
   logic signed [VALUE_W-1:0] rd_a_data;
   logic signed [VALUE_W-1:0] rd_b_data;
   logic signed [VALUE_W-1:0] fold_a;
   logic signed [VALUE_W-1:0] fold_b;

   // Node memory.
   rmst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign clear_busy    = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_is_answer = rsp_ans_ff;

   // Query fold: take the left and right boundary nodes that were picked.
   assign fold_a = use_l_ff ? max_s64(best_ff, rd_a_data) : best_ff;
   assign fold_b = use_r_ff ? max_s64(fold_a, rd_b_data) : fold_a;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      rnode_in     = rnode_ff;
      value_in     = value_ff;
      best_in      = best_ff;
      use_l_in     = use_l_ff;
      use_r_in     = use_r_ff;
      is_answer_in = is_answer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_max_in   = rsp_max_ff;
      rsp_ans_in   = rsp_ans_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = node_ff[NW-1:0];
      wr_data      = '0;
      rd_a_addr    = node_ff[NW-1:0];
      rd_b_addr    = rnode_ff[NW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (node_ff == CW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (!queue_empty) begin
               pop          = 1'b1;
               best_in      = '0;
               value_in     = head.value;
               is_answer_in = (head.action == ACT_QUERY);
               case (head.action)
                  ACT_LOAD: begin
                     wr_en    = head.leaf_ok;
                     wr_addr  = NW'(SPAN + 32'(head.leaf_index));
                     wr_data  = head.value;
                     state_in = ST_DONE;
                  end
                  ACT_REBUILD: begin
                     node_in  = CW'(SPAN - 1);
                     state_in = ST_RB_READ;
                  end
                  ACT_CHMAX: begin
                     node_in  = CW'(SPAN + 32'(head.leaf_index));
                     state_in = head.leaf_ok ? ST_UP_READ : ST_DONE;
                  end
                  default: begin
                     node_in  = CW'(SPAN + 32'(head.range_lo));
                     rnode_in = CW'(SPAN + 32'(head.range_hi));
                     state_in = head.is_empty ? ST_DONE : ST_Q_ISSUE;
                  end
               endcase
            end
         end

         // Rebuild: read both children, then write their maximum.
         ST_RB_READ: begin
            rd_a_addr = NW'({node_ff, 1'b0});
            rd_b_addr = NW'({node_ff, 1'b1});
            state_in  = ST_RB_WRITE;
         end

         ST_RB_WRITE: begin
            wr_en   = 1'b1;
            wr_data = max_s64(rd_a_data, rd_b_data);
            if (node_ff == CW'(1)) begin
               state_in = ST_DONE;
            end else begin
               node_in  = node_ff - 1'b1;
               state_in = ST_RB_READ;
            end
         end

         // Raise: read a node, write it back raised, step to the parent.
         ST_UP_READ: begin
            state_in = ST_UP_WRITE;
         end

         ST_UP_WRITE: begin
            wr_en   = 1'b1;
            wr_data = max_s64(rd_a_data, value_ff);
            if (node_ff == CW'(1)) begin
               state_in = ST_DONE;
            end else begin
               node_in  = node_ff >> 1;
               state_in = ST_UP_READ;
            end
         end

         // Query: read the boundary nodes of this level, move both ends up.
         ST_Q_ISSUE: begin
            rd_b_addr = NW'(rnode_ff - 1'b1);
            use_l_in  = node_ff[0];
            use_r_in  = rnode_ff[0];
            node_in   = (node_ff + CW'(node_ff[0])) >> 1;
            rnode_in  = rnode_ff >> 1;
            state_in  = ST_Q_FOLD;
         end

         ST_Q_FOLD: begin
            best_in  = fold_b;
            state_in = (node_ff < rnode_ff) ? ST_Q_ISSUE : ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = is_answer_ff ? best_ff : '0;
               rsp_ans_in   = is_answer_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rnode_ff     <= rnode_in;
      value_ff     <= value_in;
      best_ff      <= best_in;
      use_l_ff     <= use_l_in;
      use_r_ff     <= use_r_in;
      is_answer_ff <= is_answer_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_ans_ff   <= rsp_ans_in;
   end

endmodule

`default_nettype wire

// ===== design/range_max_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_max_segment_tree: segment tree of signed 64-bit maxima
// Leaf load, rebuild, leaf raise and half-open range maximum over LEAVES
// leaves, with one response transaction per request transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Carries
//   req_      in          req_valid / req_ready  action, leaf, value, range
//   rsp_      out         rsp_valid / rsp_ready  max_value, is_answer
//
// Load writes the leaf directly; raise reads and rewrites each node from the
// leaf up to the root; query reads the boundary nodes level by level; rebuild
// rewrites every inner node bottom-up. SPAN is LEAVES rounded up to a power
// of two. After reset all 2*SPAN nodes of the node memory are cleared to zero;
// req_ready is low meanwhile. A four-entry command queue lets requests be taken
// while the back end works or a response waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_segment_tree import rmst_pkg::*; #(
   parameter int LEAVES = LEAVES_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ACT_W-1:0]          req_action,
   input  wire logic [LEAF_W-1:0]         req_leaf_index,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [RANGE_W-1:0]        req_range_lo,
   input  wire logic [RANGE_W-1:0]        req_range_hi,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_max_value,
   output logic                           rsp_is_answer
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    queue_full;
   logic    queue_empty;
   logic    clear_busy;

   // Request intake.
   rmst_front #(
      .LEAVES (LEAVES)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_leaf_index (req_leaf_index),
      .req_value      (req_value),
      .req_range_lo   (req_range_lo),
      .req_range_hi   (req_range_hi),
      .queue_full     (queue_full),
      .clear_busy     (clear_busy),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // Command queue.
   rmst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // Tree sequencer and node memory.
   rmst_back #(
      .LEAVES (LEAVES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .clear_busy    (clear_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_value (rsp_max_value),
      .rsp_is_answer (rsp_is_answer)
   );

endmodule

`default_nettype wire
